@@ hdl/bmhq_pkg.sv @@
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

	localparam int unsigned CAPACITY_DEF  = 256;
	localparam int unsigned KEY_WIDTH_DEF = 16;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// row command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/bmhq_if.sv @@
// ---------------------------------------------------------------------------
// bmhq request / response channels
// Valid/ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_req_if #(
	parameter int unsigned KEY_WIDTH = 16
);
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic signed [KEY_WIDTH-1:0] key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

interface bmhq_rsp_if #(
	parameter int unsigned KEY_WIDTH   = 16,
	parameter int unsigned COUNT_WIDTH = 9
);
	logic                        valid;
	logic                        ready;
	logic signed [KEY_WIDTH-1:0] min_key;
	logic [1:0]                  status;
	logic [COUNT_WIDTH-1:0]      count;

	modport source (output valid, output min_key, output status, output count, input ready);
	modport sink   (input valid, input min_key, input status, input count, output ready);
endinterface

`default_nettype wire

@@ hdl/binary_min_heap_queue_top.sv @@
// ---------------------------------------------------------------------------
// binary_min_heap_queue_top
// Min priority queue built as a row of cells kept in ascending key order.
// ---------------------------------------------------------------------------
//  channel | dir | handshake   | word
//  req     | in  | valid/ready | func, key
//  rsp     | out | valid/ready | min_key, status, count
//
//  one request word per cycle; its response is registered and shows in the
//  cycle after acceptance. the whole cell row compares against the new key
//  in parallel and shifts by one slot on acceptance.
//  reset clears the entry count and the cell valid bits.
//  req is held off only while a response waits and rsp is not ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue_top #(
	parameter int unsigned CAPACITY  = bmhq_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
	input wire        clk,
	input wire        arst_n,
	bmhq_req_if.sink  req,
	bmhq_rsp_if.source rsp
);
	import bmhq_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	logic [CW-1:0]               count_q;
	logic                        rsp_valid_q;
	logic signed [KEY_WIDTH-1:0] min_key_q;
	status_t                     status_q;
	logic [CW-1:0]               count_out_q;

	logic                        accept;
	logic                        full;
	logic                        empty;
	cell_cmd_t                   cmd;

	logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0]         cell_valid;
	logic [CAPACITY-1:0]         cell_gt;

	assign accept = req.valid && req.ready;
	assign full   = (count_q == CAP_CNT);
	assign empty  = (count_q == '0);

	assign req.ready   = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.min_key = min_key_q;
	assign rsp.status  = status_q;
	assign rsp.count   = count_out_q;

	always_comb begin
		cmd.ins = accept && (req.func == FUNC_INSERT) && !full;
		cmd.rem = accept && (req.func == FUNC_REMOVE) && !empty;
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				bmhq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cmd         (cmd),
					.ins_key     (req.key),
					.left_key    (req.key),
					.left_valid  (1'b1),
					.left_gt     (1'b0),
					.right_key   (cell_key[gi+1]),
					.right_valid (cell_valid[gi+1]),
					.key         (cell_key[gi]),
					.valid       (cell_valid[gi]),
					.gt          (cell_gt[gi])
				);
			end else if (gi == CAPACITY - 1) begin : g_last
				bmhq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cmd         (cmd),
					.ins_key     (req.key),
					.left_key    (cell_key[gi-1]),
					.left_valid  (cell_valid[gi-1]),
					.left_gt     (cell_gt[gi-1]),
					.right_key   (cell_key[gi]),
					.right_valid (1'b0),
					.key         (cell_key[gi]),
					.valid       (cell_valid[gi]),
					.gt          (cell_gt[gi])
				);
			end else begin : g_mid
				bmhq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cmd         (cmd),
					.ins_key     (req.key),
					.left_key    (cell_key[gi-1]),
					.left_valid  (cell_valid[gi-1]),
					.left_gt     (cell_gt[gi-1]),
					.right_key   (cell_key[gi+1]),
					.right_valid (cell_valid[gi+1]),
					.key         (cell_key[gi]),
					.valid       (cell_valid[gi]),
					.gt          (cell_gt[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (cmd.ins) begin
				min_key_q   <= '0;
				status_q    <= STATUS_OK;
				count_out_q <= count_q + CW'(1);
			end else if (cmd.rem) begin
				min_key_q   <= cell_key[0];
				status_q    <= STATUS_OK;
				count_out_q <= count_q - CW'(1);
			end else if (req.func == FUNC_INSERT) begin
				min_key_q   <= '0;
				status_q    <= STATUS_FULL;
				count_out_q <= count_q;
			end else begin
				min_key_q   <= '0;
				status_q    <= STATUS_EMPTY;
				count_out_q <= count_q;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == !empty)
		else $error("head cell valid disagrees with entry count");

	a_remove_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |=> (min_key_q == $past(cell_key[0])) && (status_q == STATUS_OK))
		else $error("remove did not answer the head key");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !accept)
		else $error("request taken while response stalled");

endmodule

`default_nettype wire

@@ hdl/bmhq_cell.sv @@
// ---------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted key row. Opens a gap for an insert by taking its
// left neighbor's key, and closes the gap on a remove by taking its right one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_cell #(
	parameter int unsigned KEY_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire bmhq_pkg::cell_cmd_t     cmd,
	input  wire signed [KEY_WIDTH-1:0]   ins_key,
	input  wire signed [KEY_WIDTH-1:0]   left_key,
	input  wire                          left_valid,
	input  wire                          left_gt,
	input  wire signed [KEY_WIDTH-1:0]   right_key,
	input  wire                          right_valid,
	output logic signed [KEY_WIDTH-1:0]  key,
	output logic                         valid,
	output logic                         gt
);
	import bmhq_pkg::*;

	logic signed [KEY_WIDTH-1:0] key_q;
	logic                        valid_q;

	// new key goes at or before this slot
	assign gt    = !valid_q || (ins_key < key_q);
	assign key   = key_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end else if (cmd.rem) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			key_q <= left_gt ? left_key : ins_key;
		end else if (cmd.rem) begin
			key_q <= right_key;
		end
	end

endmodule

`default_nettype wire
